// ----- rtl/sdcd_pkg.sv -----
// Shared constants and types for the serial drive command decoder.
package sdcd_pkg;

  localparam logic [7:0] CMD_FWD   = 8'h46;
  localparam logic [7:0] CMD_BACK  = 8'h66;
  localparam logic [7:0] CMD_RIGHT = 8'h52;
  localparam logic [7:0] CMD_LEFT  = 8'h4C;
  localparam logic [7:0] CMD_SPINL = 8'h41;
  localparam logic [7:0] CMD_SPINR = 8'h44;
  localparam logic [7:0] CMD_STOP  = 8'h53;

  localparam logic [3:0] DIR_STOP  = 4'h0;
  localparam logic [3:0] DIR_FWD   = 4'h6;
  localparam logic [3:0] DIR_BACK  = 4'h9;
  localparam logic [3:0] DIR_SPINL = 4'h5;
  localparam logic [3:0] DIR_SPINR = 4'hA;

  localparam logic [7:0] DIGIT_ZERO = 8'h30;
  localparam logic [7:0] DIGIT_NINE = 8'h39;
  localparam logic [7:0] TURN_BASE  = 8'd250;
  localparam logic [7:0] FULL_DUTY  = 8'd255;
  localparam logic [9:0] TURN_MAX   = 10'd999;

  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 40;

  typedef struct packed {
    logic [9:0] turn_amount;
    logic [7:0] right_duty;
    logic [7:0] left_duty;
    logic [3:0] direction;
    logic [7:0] echo_byte;
  } sdcd_result_t;

endpackage

// ----- rtl/sdcd_core.sv -----
// Digit assembly and drive command state for the serial drive command decoder.
module sdcd_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic [7:0]            rx_byte,
  output sdcd_pkg::sdcd_result_t result
);
  import sdcd_pkg::*;

  logic [1:0] digit_position;
  logic [3:0] hundreds_digit;
  logic [3:0] tens_digit;
  logic [3:0] ones_digit;
  logic [9:0] assembled_value;
  logic [3:0] drive_nibble;
  logic [7:0] left_compare;
  logic [7:0] right_compare;

  logic       is_digit;
  logic [3:0] hundreds_digit_next;
  logic [3:0] tens_digit_next;
  logic [3:0] ones_digit_next;
  logic [9:0] assembled_value_next;
  logic [3:0] drive_nibble_next;
  logic [7:0] left_compare_next;
  logic [7:0] right_compare_next;
  logic [7:0] reduced;

  always_comb begin
    is_digit = (rx_byte >= DIGIT_ZERO) && (rx_byte <= DIGIT_NINE);
    hundreds_digit_next  = hundreds_digit;
    tens_digit_next      = tens_digit;
    ones_digit_next      = ones_digit;
    assembled_value_next = assembled_value;
    case (digit_position)
      2'd0: if (is_digit) hundreds_digit_next = rx_byte[3:0];
      2'd1: if (is_digit) tens_digit_next = rx_byte[3:0];
      2'd2: if (is_digit) ones_digit_next = rx_byte[3:0];
      default: begin
        assembled_value_next = 10'({6'd0, hundreds_digit} * 10'd100)
                             + 10'({6'd0, tens_digit} * 10'd10)
                             + {6'd0, ones_digit};
      end
    endcase

    reduced = TURN_BASE - assembled_value_next[7:0];

    drive_nibble_next  = drive_nibble;
    left_compare_next  = left_compare;
    right_compare_next = right_compare;
    case (rx_byte)
      CMD_FWD: begin
        drive_nibble_next  = DIR_FWD;
        left_compare_next  = FULL_DUTY;
        right_compare_next = FULL_DUTY;
      end
      CMD_BACK: begin
        drive_nibble_next  = DIR_BACK;
        left_compare_next  = FULL_DUTY;
        right_compare_next = FULL_DUTY;
      end
      CMD_RIGHT: begin
        drive_nibble_next  = DIR_FWD;
        left_compare_next  = TURN_BASE;
        right_compare_next = reduced;
      end
      CMD_LEFT: begin
        drive_nibble_next  = DIR_FWD;
        left_compare_next  = reduced;
        right_compare_next = TURN_BASE;
      end
      CMD_SPINL: begin
        drive_nibble_next  = DIR_SPINL;
        left_compare_next  = FULL_DUTY;
        right_compare_next = FULL_DUTY;
      end
      CMD_SPINR: begin
        drive_nibble_next  = DIR_SPINR;
        left_compare_next  = FULL_DUTY;
        right_compare_next = FULL_DUTY;
      end
      CMD_STOP: drive_nibble_next = DIR_STOP;
      default: ;
    endcase

    result.echo_byte   = rx_byte;
    result.direction   = drive_nibble_next;
    result.left_duty   = left_compare_next;
    result.right_duty  = right_compare_next;
    result.turn_amount = assembled_value_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      digit_position  <= 2'd0;
      hundreds_digit  <= 4'd0;
      tens_digit      <= 4'd0;
      ones_digit      <= 4'd0;
      assembled_value <= 10'd0;
      drive_nibble    <= DIR_STOP;
      left_compare    <= FULL_DUTY;
      right_compare   <= FULL_DUTY;
    end else if (en) begin
      digit_position  <= digit_position + 2'd1;
      hundreds_digit  <= hundreds_digit_next;
      tens_digit      <= tens_digit_next;
      ones_digit      <= ones_digit_next;
      assembled_value <= assembled_value_next;
      drive_nibble    <= drive_nibble_next;
      left_compare    <= left_compare_next;
      right_compare   <= right_compare_next;
    end
  end

endmodule

// ----- rtl/serial_drive_command_decoder.sv -----
// Top level of the serial drive command decoder: input stage, decode, result stage.
//
// Each received byte on the slave stream yields exactly one result transfer on the
// master stream, in order: the byte echoed back together with the direction nibble,
// both PWM duties and the last assembled three digit turn value, all as they stand
// after that byte. Each byte passes through one input register and then one result
// register, and a stall on m_tready can hold it in either; a new byte is taken every
// cycle while the master side keeps accepting, so throughput is one byte per cycle.
// Backpressure from m_tready holds both stages in place and stops the input side only
// when both are full.
module serial_drive_command_decoder (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [sdcd_pkg::IN_DATA_W-1:0]     s_tdata,  // [7:0] rx_byte
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [sdcd_pkg::OUT_DATA_W-1:0]    m_tdata   // [7:0] echo_byte, [11:8] direction,
                                                       // [19:12] left_duty, [27:20] right_duty,
                                                       // [37:28] turn_amount, [39:38] zero
);
  import sdcd_pkg::*;

  logic         in_valid;
  logic [7:0]   in_byte;
  logic         advance;
  sdcd_result_t result;
  sdcd_result_t out_result;

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
    end
  end

  sdcd_core u_core (
    .clk     (clk),
    .rst     (rst),
    .en      (in_valid && advance),
    .rx_byte (in_byte),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
    end
    if (advance && in_valid) begin
      out_result <= result;
    end
  end

  assign m_tdata = {2'b00, out_result.turn_amount, out_result.right_duty,
                    out_result.left_duty, out_result.direction, out_result.echo_byte};

`ifndef SYNTHESIS
  a_rise_from_input: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(in_valid))
    else $error("result appeared without a byte in the input stage");

  a_stall_holds_input: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready && in_valid) |=> (in_valid && $stable(in_byte)))
    else $error("input stage changed while the result stage was stalled");

  a_turn_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_result.turn_amount <= TURN_MAX))
    else $error("turn value out of range");

  a_direction_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_result.direction == DIR_STOP || out_result.direction == DIR_FWD ||
                  out_result.direction == DIR_BACK || out_result.direction == DIR_SPINL ||
                  out_result.direction == DIR_SPINR))
    else $error("illegal direction nibble");
`endif

endmodule

// ----- tb/sdcd_checker.sv -----
// Predicts each decoded result from the input stream and checks the output stream against it.
module sdcd_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [sdcd_pkg::IN_DATA_W-1:0]  s_tdata,  // [7:0] rx_byte
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [sdcd_pkg::OUT_DATA_W-1:0] m_tdata,  // [7:0] echo_byte, [11:8] direction,
                                                    // [19:12] left_duty, [27:20] right_duty,
                                                    // [37:28] turn_amount, [39:38] zero
  output int                              fail_count,
  output int                              pending,
  output int                              checked_count
);
  import sdcd_pkg::*;

  logic [1:0] digit_pos;
  logic [3:0] hundreds;
  logic [3:0] tens;
  logic [3:0] ones;
  logic [9:0] turn_value;
  logic [3:0] drive_dir;
  logic [7:0] left_cmp;
  logic [7:0] right_cmp;

  sdcd_result_t pending_results[$];
  sdcd_result_t want;
  sdcd_result_t seen;
  int           mismatches = 0;
  int           checked = 0;

  function automatic sdcd_result_t apply_rx_byte(input logic [7:0] rx);
    logic         is_digit;
    logic [3:0]   digit;
    logic [7:0]   reduced;
    sdcd_result_t res;
    is_digit = (rx >= DIGIT_ZERO) && (rx <= DIGIT_NINE);
    digit    = 4'(rx - DIGIT_ZERO);
    case (digit_pos)
      2'd0: if (is_digit) hundreds = digit;
      2'd1: if (is_digit) tens = digit;
      2'd2: if (is_digit) ones = digit;
      default: turn_value = 10'(int'(hundreds) * 100 + int'(tens) * 10 + int'(ones));
    endcase
    digit_pos = digit_pos + 2'd1;
    reduced = 8'(int'(TURN_BASE) - int'(turn_value));
    case (rx)
      CMD_FWD: begin
        drive_dir = DIR_FWD;   left_cmp = FULL_DUTY; right_cmp = FULL_DUTY;
      end
      CMD_BACK: begin
        drive_dir = DIR_BACK;  left_cmp = FULL_DUTY; right_cmp = FULL_DUTY;
      end
      CMD_RIGHT: begin
        drive_dir = DIR_FWD;   left_cmp = TURN_BASE; right_cmp = reduced;
      end
      CMD_LEFT: begin
        drive_dir = DIR_FWD;   left_cmp = reduced;   right_cmp = TURN_BASE;
      end
      CMD_SPINL: begin
        drive_dir = DIR_SPINL; left_cmp = FULL_DUTY; right_cmp = FULL_DUTY;
      end
      CMD_SPINR: begin
        drive_dir = DIR_SPINR; left_cmp = FULL_DUTY; right_cmp = FULL_DUTY;
      end
      CMD_STOP: drive_dir = DIR_STOP;
      default: ;
    endcase
    res.echo_byte   = rx;
    res.direction   = drive_dir;
    res.left_duty   = left_cmp;
    res.right_duty  = right_cmp;
    res.turn_amount = turn_value;
    return res;
  endfunction

  task automatic compare_field(input string field, input int unsigned exp_val,
                               input int unsigned got_val);
    if (exp_val != got_val) begin
      $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $time, field, exp_val,
               got_val);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      digit_pos  = 2'd0;
      hundreds   = 4'd0;
      tens       = 4'd0;
      ones       = 4'd0;
      turn_value = 10'd0;
      drive_dir  = DIR_STOP;
      left_cmp   = FULL_DUTY;
      right_cmp  = FULL_DUTY;
      pending_results.delete();
    end else begin
      if (s_tvalid && s_tready) pending_results.push_back(apply_rx_byte(s_tdata));
      if (m_tvalid && m_tready) begin
        seen = m_tdata[37:0];
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected transfer, expected none actual 0x%0h", $time, m_tdata);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          compare_field("echo_byte", 32'(want.echo_byte), 32'(seen.echo_byte));
          compare_field("direction", 32'(want.direction), 32'(seen.direction));
          compare_field("left_duty", 32'(want.left_duty), 32'(seen.left_duty));
          compare_field("right_duty", 32'(want.right_duty), 32'(seen.right_duty));
          compare_field("turn_amount", 32'(want.turn_amount), 32'(seen.turn_amount));
          compare_field("padding", 32'(0), 32'(m_tdata[39:38]));
          checked++;
        end
      end
    end
    fail_count    <= mismatches;
    pending       <= pending_results.size();
    checked_count <= checked;
  end

endmodule

// ----- tb/tb_serial_drive_command_decoder.sv -----
// Top of the serial drive command decoder testbench: stimulus, receiver stalls and verdict.
module tb_serial_drive_command_decoder;
  import sdcd_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 8;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;   // [7:0] rx_byte
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;        // [7:0] echo_byte, [11:8] direction,
                                         // [19:12] left_duty, [27:20] right_duty,
                                         // [37:28] turn_amount, [39:38] zero

  int fail_count;
  int pending;
  int checked_count;
  int bytes_sent = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int quiet_cycles = 0;
  int hold_left = 0;
  logic start_hold = 1'b0;
  logic hold_taken = 1'b0;

  logic [7:0] drive_cmds [0:6] = '{CMD_FWD, CMD_BACK, CMD_RIGHT, CMD_LEFT,
                                   CMD_SPINL, CMD_SPINR, CMD_STOP};

  // digits land on positions 0..2, commands on position 3 in rows 2-4; rows 1, 5 and 6 break that
  logic [7:0] directed_bytes [0:23] = '{
    CMD_FWD, CMD_BACK, CMD_SPINL, CMD_SPINR,
    DIGIT_NINE, DIGIT_NINE, DIGIT_NINE, CMD_RIGHT,
    DIGIT_ZERO, DIGIT_ZERO, DIGIT_ZERO, CMD_LEFT,
    8'h32, 8'h35, 8'h31, CMD_STOP,
    8'h00, 8'hFF, 8'h2F, 8'h37,
    8'h3A, CMD_LEFT, CMD_RIGHT, 8'h35
  };

  always #1 clk = ~clk;

  serial_drive_command_decoder uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  sdcd_checker drive_check (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .fail_count    (fail_count),
    .pending       (pending),
    .checked_count (checked_count)
  );

  // hold off the output side once for a long stretch, else stall at random
  always @(posedge clk) begin
    if (hold_left > 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (start_hold && !hold_taken) begin
      m_tready   <= 1'b0;
      hold_left  <= HOLD_CYCLES;
      hold_taken <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] rx);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= rx;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    bytes_sent++;
  endtask

  // mostly aligned digit frames closed by a command, the rest loose noise
  task automatic send_random(input int count);
    int stop_at;
    stop_at = bytes_sent + count;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(4) != 0) begin
        while (bytes_sent % 4 != 0) send_byte(8'($urandom_range(255)));
        repeat (3) begin
          if ($urandom_range(9) == 0) send_byte(8'($urandom_range(255)));
          else send_byte(8'(DIGIT_ZERO + $urandom_range(9)));
        end
        if ($urandom_range(7) == 0) send_byte(8'($urandom_range(255)));
        else send_byte(drive_cmds[$urandom_range(6)]);
      end else begin
        repeat ($urandom_range(5, 1)) send_byte(8'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 24;
    recv_idle_pct <= 55;
    foreach (directed_bytes[i]) send_byte(directed_bytes[i]);
    send_random(700);
    send_idle_pct = 55;
    recv_idle_pct <= 24;
    send_random(700);
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    start_hold <= 1'b1;
    send_random(600);
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d bytes: digit frames, every drive command, stray and noise bytes.",
             bytes_sent);
    $display("Checked %0d results under three stall patterns and one long output hold-off.",
             checked_count);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/sdcd_pkg.sv
rtl/sdcd_core.sv
rtl/serial_drive_command_decoder.sv
tb/sdcd_checker.sv
tb/tb_serial_drive_command_decoder.sv
